// ===== design/sitoa_pkg.sv =====
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared widths, character codes and controller/datapath handshake types for
// the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package sitoa_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int MAX_DIGITS = 10;
    localparam int COUNT_W    = $clog2(MAX_DIGITS + 1);

    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;

    // ceil(2^35 / 10): floor(n * RECIP10 / 2^35) == n / 10 for any 32-bit n
    localparam logic [VALUE_W-1:0] RECIP10    = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    typedef struct packed {
        logic load;   // capture sign and magnitude of a new value
        logic step;   // peel off one decimal digit
        logic pop;    // retire the character on the output
    } sitoa_cmd_t;

    typedef struct packed {
        logic conv_done;  // the digit being produced is the leading one
        logic emit_last;  // the character on the output ends the text
    } sitoa_status_t;

endpackage

// ===== design/sitoa_in_if.sv =====
// ----------------------------------------------------------------------------
// sitoa_in_if
// Input channel: one signed 32-bit value per transfer.
// ----------------------------------------------------------------------------
interface sitoa_in_if;
    import sitoa_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);

endinterface

// ===== design/sitoa_out_if.sv =====
// ----------------------------------------------------------------------------
// sitoa_out_if
// Output channel: one ASCII character per transfer, last marks end of text.
// ----------------------------------------------------------------------------
interface sitoa_out_if;
    import sitoa_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);

endinterface

// ===== design/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed 32-bit integer to decimal ASCII text, one character per transfer.
// ----------------------------------------------------------------------------
// One value is converted at a time. After a value transfer the block runs
// the divide-by-ten loop once per decimal digit (1 to 10 digits), a single
// reciprocal multiply per digit, and then offers one character per cycle
// while the output is ready: a '-' for negative values, then the digits most
// significant first, with last set on the final digit. A new value is taken
// once the last character of the previous one has transferred.
module signed_int_to_decimal_ascii (
    input  logic        clk,
    input  logic        rst_n,
    sitoa_in_if.sink    in_ch,
    sitoa_out_if.source out_ch
);
    import sitoa_pkg::*;

    sitoa_cmd_t    cmd;
    sitoa_status_t status;

    sitoa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    sitoa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .value     (in_ch.value),
        .status    (status),
        .char_code (out_ch.char_code)
    );

    assign out_ch.last = status.emit_last;

endmodule

// ===== design/sitoa_datapath.sv =====
// ----------------------------------------------------------------------------
// sitoa_datapath
// Magnitude register, divide-by-ten step and digit stack. Digits are pushed
// least significant first and popped most significant first.
// ----------------------------------------------------------------------------
module sitoa_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sitoa_pkg::sitoa_cmd_t              cmd,
    input  logic signed [sitoa_pkg::VALUE_W-1:0] value,
    output sitoa_pkg::sitoa_status_t           status,
    output logic [sitoa_pkg::CHAR_W-1:0]       char_code
);
    import sitoa_pkg::*;

    logic [VALUE_W-1:0]   mag_reg,  mag_next;
    logic                 neg_reg,  neg_next;
    logic [COUNT_W-1:0]   cnt_reg,  cnt_next;
    logic [DIGIT_W-1:0]   digit_reg  [MAX_DIGITS];
    logic [DIGIT_W-1:0]   digit_next [MAX_DIGITS];

    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W-1:0]   quot;
    logic [VALUE_W-1:0]   quot_x10;
    logic [VALUE_W-1:0]   diff;
    logic [DIGIT_W-1:0]   rem;

    // reciprocal multiply, then remainder by shift-add and subtract
    assign prod     = (2*VALUE_W)'(mag_reg) * (2*VALUE_W)'(RECIP10);
    assign quot     = VALUE_W'(prod[2*VALUE_W-1:RECIP_SHIFT]);
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign diff     = mag_reg - quot_x10;
    assign rem      = diff[DIGIT_W-1:0];

    always_comb
    begin
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        digit_next = digit_reg;
        if (cmd.load)
        begin
            neg_next = value[VALUE_W-1];
            mag_next = value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value))
                                        : VALUE_W'(value);
            cnt_next = '0;
        end
        else if (cmd.step)
        begin
            mag_next      = quot;
            cnt_next      = cnt_reg + COUNT_W'(1);
            digit_next[0] = rem;
            for (int i = 1; i < MAX_DIGITS; i++)
            begin
                digit_next[i] = digit_reg[i-1];
            end
        end
        else if (cmd.pop)
        begin
            if (neg_reg)
            begin
                neg_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - COUNT_W'(1);
                for (int i = 0; i < MAX_DIGITS - 1; i++)
                begin
                    digit_next[i] = digit_reg[i+1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            neg_reg <= neg_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        digit_reg <= digit_next;
    end

    assign status.conv_done = (quot == '0);
    assign status.emit_last = !neg_reg && (cnt_reg == COUNT_W'(1));
    assign char_code = neg_reg ? CHAR_MINUS : (CHAR_ZERO + CHAR_W'(digit_reg[0]));

    a_step_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (cnt_reg < COUNT_W'(MAX_DIGITS)))
        else $error("digit stack overflow");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> (digit_reg[0] <= DIGIT_MAX))
        else $error("remainder out of decimal range");

endmodule

// ===== design/sitoa_ctrl.sv =====
// ----------------------------------------------------------------------------
// sitoa_ctrl
// Sequencer: take a value, run the digit loop until the quotient is zero,
// then hand out characters one per output transfer.
// ----------------------------------------------------------------------------
module sitoa_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  logic                     out_ready,
    input  sitoa_pkg::sitoa_status_t status,
    output sitoa_pkg::sitoa_cmd_t    cmd
);
    import sitoa_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.step = 1'b1;
                if (status.conv_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.pop = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_load_to_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_CONV))
        else $error("accepted value did not start conversion");

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.step, cmd.pop}))
        else $error("conflicting datapath commands");

    a_last_ends_text: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && status.emit_last) |=> in_ready)
        else $error("controller did not return to idle after last character");

endmodule
